// ===== hdl/plex_pkg.sv =====
// Shared types, token codes and character lookup functions for the plural
// expression tokenizer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plex_pkg;

    // Width of the result value field on the output stream
    localparam int unsigned OUT_VALUE_W = 64;

    // Token kinds emitted on the master side
    typedef enum logic [4:0] {
        TK_END   = 5'd0,
        TK_NUM   = 5'd1,
        TK_VAR   = 5'd2,
        TK_PLUS  = 5'd3,
        TK_MINUS = 5'd4,
        TK_MUL   = 5'd5,
        TK_DIV   = 5'd6,
        TK_MOD   = 5'd7,
        TK_EQ    = 5'd8,
        TK_NE    = 5'd9,
        TK_LT    = 5'd10,
        TK_LE    = 5'd11,
        TK_GT    = 5'd12,
        TK_GE    = 5'd13,
        TK_AND   = 5'd14,
        TK_OR    = 5'd15,
        TK_NOT   = 5'd16,
        TK_QUEST = 5'd17,
        TK_COLON = 5'd18,
        TK_LPAR  = 5'd19,
        TK_RPAR  = 5'd20
    } kind_t;

    // First character of a possible two-character operator
    typedef enum logic [2:0] {
        PEND_NONE = 3'd0,
        PEND_EQ   = 3'd1,
        PEND_BANG = 3'd2,
        PEND_LT   = 3'd3,
        PEND_GT   = 3'd4,
        PEND_AMP  = 3'd5,
        PEND_BAR  = 3'd6
    } pend_t;

    // Token for a character that stands alone; TK_END means none
    function automatic kind_t char_kind(input logic [7:0] c);
        kind_t k;
        k = TK_END;
        case (c)
            8'h6E:   k = TK_VAR;   // n
            8'h2B:   k = TK_PLUS;
            8'h2D:   k = TK_MINUS;
            8'h2A:   k = TK_MUL;
            8'h2F:   k = TK_DIV;
            8'h25:   k = TK_MOD;
            8'h3F:   k = TK_QUEST;
            8'h3A:   k = TK_COLON;
            8'h28:   k = TK_LPAR;
            8'h29:   k = TK_RPAR;
            default: k = TK_END;
        endcase
        return k;
    endfunction

    // Pending code for a character that may open a pair
    function automatic pend_t char_pend(input logic [7:0] c);
        pend_t p;
        p = PEND_NONE;
        case (c)
            8'h3D:   p = PEND_EQ;
            8'h21:   p = PEND_BANG;
            8'h3C:   p = PEND_LT;
            8'h3E:   p = PEND_GT;
            8'h26:   p = PEND_AMP;
            8'h7C:   p = PEND_BAR;
            default: p = PEND_NONE;
        endcase
        return p;
    endfunction

    // Pending character emitted alone; lone = & | are dropped (TK_END)
    function automatic kind_t single_of(input pend_t p);
        kind_t k;
        k = TK_END;
        case (p)
            PEND_BANG: k = TK_NOT;
            PEND_LT:   k = TK_LT;
            PEND_GT:   k = TK_GT;
            default:   k = TK_END;
        endcase
        return k;
    endfunction

    // Two-character operator formed by pending p and character c
    function automatic kind_t pair_of(input pend_t p, input logic [7:0] c);
        kind_t k;
        k = TK_END;
        if (c == 8'h3D) begin
            case (p)
                PEND_EQ:   k = TK_EQ;
                PEND_BANG: k = TK_NE;
                PEND_LT:   k = TK_LE;
                PEND_GT:   k = TK_GE;
                default:   k = TK_END;
            endcase
        end else if (p == PEND_AMP && c == 8'h26) begin
            k = TK_AND;
        end else if (p == PEND_BAR && c == 8'h7C) begin
            k = TK_OR;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/plural_expression_tokenizer.sv =====
// Streaming tokenizer for C-like plural expressions: one byte in, up to three
// tokens out. Depends on plex_pkg.
//
// Usage:
//   Slave side carries one character per beat: s_tdata[7:0] is the byte,
//   s_tuser flags that the byte is present (low for a bubble or an empty
//   expression), s_tlast marks the final character and triggers the flush of
//   any pending number or operator followed by an END token.
//   Master side carries one token per beat: kind and value in m_tdata,
//   m_tlast high on the last token that an input beat produced.
//   Flow: a beat is registered, decoded combinationally and written to a
//   four-entry token queue, from which its first token is offered on the
//   master side. Throughput: one character per cycle while the queue holds
//   at most one token; the master side drains one token per cycle while
//   m_tready is high, so a character that yields two or three tokens holds
//   the input register until the queue has room again. Reset clears the
//   number accumulator, the pending operator, the input valid flag and the
//   queue pointers and count. A stalled receiver fills the queue, which then
//   holds the input register and drops s_tready; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module plural_expression_tokenizer #(
    parameter int unsigned VALUE_WIDTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tuser,   // [0] char_present
    input  wire logic        s_tlast,   // is_last
    // master side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [4:0] token_kind, [68:5] number_value
    output logic             m_tlast    // run_end
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned NCAND = 7;

    // input register
    logic                   in_valid_reg;
    logic [7:0]             in_char_reg;
    logic                   in_present_reg;
    logic                   in_last_reg;

    // tokenizer state
    logic                   in_number_reg, in_number_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    plex_pkg::pend_t        pend_reg, pend_next;

    // token queue
    plex_pkg::kind_t        q_kind_reg [DEPTH];
    logic [VALUE_WIDTH-1:0] q_val_reg  [DEPTH];
    logic                   q_last_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;

    logic                   adv;
    logic                   pop;
    logic [1:0]             push_n;

    // decode signals
    logic                   is_digit;
    plex_pkg::kind_t        pair_k, pend_single_k, chr_k, mid_single_k;
    plex_pkg::pend_t        chr_p;
    logic                   pair_hit;
    logic                   in_num_mid;
    logic [VALUE_WIDTH-1:0] acc_mid, acc_base;
    plex_pkg::pend_t        pend_mid;

    logic                   cand_v   [NCAND];
    plex_pkg::kind_t        cand_k   [NCAND];
    logic [VALUE_WIDTH-1:0] cand_val [NCAND];

    plex_pkg::kind_t        slot_k   [3];
    logic [VALUE_WIDTH-1:0] slot_val [3];
    logic                   slot_last[3];

    // Queue room for a worst-case item of three tokens
    assign adv      = in_valid_reg && (count_reg <= CNT_W'(DEPTH - 3));
    assign s_tready = !in_valid_reg || adv;
    assign pop      = m_tvalid && m_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg    <= s_tdata;
            in_present_reg <= s_tuser;
            in_last_reg    <= s_tlast;
        end
    end

    // Character decode: pair match, pending flush, number run, single token
    always_comb
    begin
        is_digit      = (in_char_reg >= 8'h30) && (in_char_reg <= 8'h39);
        pair_k        = plex_pkg::pair_of(pend_reg, in_char_reg);
        pair_hit      = in_present_reg && (pair_k != plex_pkg::TK_END);
        pend_single_k = plex_pkg::single_of(pend_reg);
        chr_k         = plex_pkg::char_kind(in_char_reg);
        chr_p         = plex_pkg::char_pend(in_char_reg);
        acc_base      = in_number_reg ? acc_reg : '0;

        in_num_mid = in_number_reg;
        acc_mid    = acc_reg;
        pend_mid   = pend_reg;
        if (in_present_reg)
        begin
            if (pair_hit)
            begin
                pend_mid = plex_pkg::PEND_NONE;
            end
            else if (is_digit)
            begin
                // accum * 10 + digit, wrapping at VALUE_WIDTH
                acc_mid    = (acc_base << 3) + (acc_base << 1)
                           + VALUE_WIDTH'(in_char_reg[3:0]);
                in_num_mid = 1'b1;
                pend_mid   = plex_pkg::PEND_NONE;
            end
            else
            begin
                acc_mid    = '0;
                in_num_mid = 1'b0;
                pend_mid   = chr_p;
            end
        end
        mid_single_k = plex_pkg::single_of(pend_mid);

        // Candidate tokens in emission order
        cand_v[0]   = pair_hit;
        cand_k[0]   = pair_k;
        cand_val[0] = '0;
        cand_v[1]   = in_present_reg && !pair_hit && (pend_single_k != plex_pkg::TK_END);
        cand_k[1]   = pend_single_k;
        cand_val[1] = '0;
        cand_v[2]   = in_present_reg && !pair_hit && !is_digit && in_number_reg;
        cand_k[2]   = plex_pkg::TK_NUM;
        cand_val[2] = acc_reg;
        cand_v[3]   = in_present_reg && !pair_hit && !is_digit
                    && (chr_k != plex_pkg::TK_END);
        cand_k[3]   = chr_k;
        cand_val[3] = '0;
        cand_v[4]   = in_last_reg && in_num_mid;
        cand_k[4]   = plex_pkg::TK_NUM;
        cand_val[4] = acc_mid;
        cand_v[5]   = in_last_reg && (mid_single_k != plex_pkg::TK_END);
        cand_k[5]   = mid_single_k;
        cand_val[5] = '0;
        cand_v[6]   = in_last_reg;
        cand_k[6]   = plex_pkg::TK_END;
        cand_val[6] = '0;

        // Next state; last item returns everything to reset
        if (in_last_reg)
        begin
            in_number_next = 1'b0;
            acc_next       = '0;
            pend_next      = plex_pkg::PEND_NONE;
        end
        else
        begin
            in_number_next = in_num_mid;
            acc_next       = acc_mid;
            pend_next      = pend_mid;
        end
    end

    // Pack valid candidates into up to three token slots
    always_comb
    begin
        push_n = 2'd0;
        for (int k = 0; k < 3; k++)
        begin
            slot_k[k]   = plex_pkg::TK_END;
            slot_val[k] = '0;
        end
        for (int i = 0; i < NCAND; i++)
        begin
            if (cand_v[i] && push_n != 2'd3)
            begin
                slot_k[push_n]   = cand_k[i];
                slot_val[push_n] = cand_val[i];
                push_n           = push_n + 2'd1;
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            slot_last[k] = (2'(k) + 2'd1 == push_n);
        end
    end

    // Tokenizer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_number_reg <= 1'b0;
            acc_reg       <= '0;
            pend_reg      <= plex_pkg::PEND_NONE;
        end
        else if (adv)
        begin
            in_number_reg <= in_number_next;
            acc_reg       <= acc_next;
            pend_reg      <= pend_next;
        end
    end

    // Token queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (adv)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + (adv ? CNT_W'(push_n) : CNT_W'(0))
                       - (pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

    // Token queue storage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (2'(k) < push_n)
                begin
                    q_kind_reg[wr_ptr_reg + PTR_W'(k)] <= slot_k[k];
                    q_val_reg[wr_ptr_reg + PTR_W'(k)]  <= slot_val[k];
                    q_last_reg[wr_ptr_reg + PTR_W'(k)] <= slot_last[k];
                end
            end
        end
    end

    // Master side beat
    assign m_tvalid = (count_reg != '0);
    assign m_tlast  = q_last_reg[rd_ptr_reg];
    assign m_tdata  = {3'b000,
                       plex_pkg::OUT_VALUE_W'(q_val_reg[rd_ptr_reg]),
                       q_kind_reg[rd_ptr_reg]};

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("token queue overfilled");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        adv && in_last_reg |=> !in_number_reg && acc_reg == '0
                               && pend_reg == plex_pkg::PEND_NONE)
        else $error("state not cleared after last character");

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        adv && in_last_reg |-> push_n != 2'd0)
        else $error("last character produced no END token");

    a_pend_no_num: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != plex_pkg::PEND_NONE |-> !in_number_reg)
        else $error("pending operator during a number run");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for plural_expression_tokenizer: random and directed
// expression text in, token stream checked beat by beat. Depends on plex_pkg.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 100000;

    // One expected token on the master side
    typedef struct {
        plex_pkg::kind_t                  kind;
        logic [plex_pkg::OUT_VALUE_W-1:0] value;
        bit                               tail;
    } token_t;

    // One character beat on the slave side
    typedef struct {
        logic [7:0] code;
        bit         present;
    } char_beat_t;

    // Tokenizer predictor plus the queue of tokens still owed by the block
    class token_scoreboard;
        token_t                           owed_q[$];
        token_t                           burst[$];
        bit                               in_digits;
        logic [plex_pkg::OUT_VALUE_W-1:0] digit_acc;
        plex_pkg::pend_t                  held_op;
        int                               errors;
        int                               checked;

        function new();
            in_digits = 1'b0;
            digit_acc = '0;
            held_op   = plex_pkg::PEND_NONE;
            errors    = 0;
            checked   = 0;
        endfunction

        function void add_token(plex_pkg::kind_t k, logic [plex_pkg::OUT_VALUE_W-1:0] v);
            token_t t;
            t.kind  = k;
            t.value = v;
            t.tail  = 1'b0;
            burst.push_back(t);
        endfunction

        // Operator emitted when the held character stands alone; TK_END = dropped
        function plex_pkg::kind_t alone_kind(plex_pkg::pend_t p);
            case (p)
                plex_pkg::PEND_BANG: return plex_pkg::TK_NOT;
                plex_pkg::PEND_LT:   return plex_pkg::TK_LT;
                plex_pkg::PEND_GT:   return plex_pkg::TK_GT;
                default:             return plex_pkg::TK_END;
            endcase
        endfunction

        // Two-character operator; TK_END = not a pair
        function plex_pkg::kind_t combo_kind(plex_pkg::pend_t p, logic [7:0] c);
            if (c == "=" && p == plex_pkg::PEND_EQ)   return plex_pkg::TK_EQ;
            if (c == "=" && p == plex_pkg::PEND_BANG) return plex_pkg::TK_NE;
            if (c == "=" && p == plex_pkg::PEND_LT)   return plex_pkg::TK_LE;
            if (c == "=" && p == plex_pkg::PEND_GT)   return plex_pkg::TK_GE;
            if (c == "&" && p == plex_pkg::PEND_AMP)  return plex_pkg::TK_AND;
            if (c == "|" && p == plex_pkg::PEND_BAR)  return plex_pkg::TK_OR;
            return plex_pkg::TK_END;
        endfunction

        function void release_held();
            plex_pkg::kind_t k;
            k = alone_kind(held_op);
            if (k != plex_pkg::TK_END)
                add_token(k, '0);
            held_op = plex_pkg::PEND_NONE;
        endfunction

        function void close_digits();
            if (in_digits)
                add_token(plex_pkg::TK_NUM, digit_acc);
            in_digits = 1'b0;
            digit_acc = '0;
        endfunction

        function void take_char(logic [7:0] c);
            plex_pkg::kind_t k;
            if (held_op != plex_pkg::PEND_NONE) begin
                k = combo_kind(held_op, c);
                if (k != plex_pkg::TK_END) begin
                    add_token(k, '0);
                    held_op = plex_pkg::PEND_NONE;
                    return;
                end
                release_held();
            end
            // digits extend the running value, wrapping at the field width
            if (c >= "0" && c <= "9") begin
                if (!in_digits)
                    digit_acc = '0;
                digit_acc = digit_acc * 10 + plex_pkg::OUT_VALUE_W'(c - "0");
                in_digits = 1'b1;
                return;
            end
            close_digits();
            case (c)
                "n":     add_token(plex_pkg::TK_VAR, '0);
                "+":     add_token(plex_pkg::TK_PLUS, '0);
                "-":     add_token(plex_pkg::TK_MINUS, '0);
                "*":     add_token(plex_pkg::TK_MUL, '0);
                "/":     add_token(plex_pkg::TK_DIV, '0);
                "%":     add_token(plex_pkg::TK_MOD, '0);
                "?":     add_token(plex_pkg::TK_QUEST, '0);
                ":":     add_token(plex_pkg::TK_COLON, '0);
                "(":     add_token(plex_pkg::TK_LPAR, '0);
                ")":     add_token(plex_pkg::TK_RPAR, '0);
                "=":     held_op = plex_pkg::PEND_EQ;
                "!":     held_op = plex_pkg::PEND_BANG;
                "<":     held_op = plex_pkg::PEND_LT;
                ">":     held_op = plex_pkg::PEND_GT;
                "&":     held_op = plex_pkg::PEND_AMP;
                "|":     held_op = plex_pkg::PEND_BAR;
                default: ;
            endcase
        endfunction

        // Accepted character beat: predict its tokens
        function void note_char(logic [7:0] c, bit present, bit last);
            burst.delete();
            if (present)
                take_char(c);
            if (last) begin
                close_digits();
                release_held();
                add_token(plex_pkg::TK_END, '0);
                in_digits = 1'b0;
                digit_acc = '0;
                held_op   = plex_pkg::PEND_NONE;
            end
            if (burst.size() > 0)
                burst[burst.size() - 1].tail = 1'b1;
            foreach (burst[i])
                owed_q.push_back(burst[i]);
        endfunction

        function bit waiting();
            return owed_q.size() != 0;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("ERROR @%0t: %s", $time, msg);
        endtask

        // Accepted token beat: compare with the oldest prediction
        task check_token(logic [4:0] kind, logic [plex_pkg::OUT_VALUE_W-1:0] value,
                         logic tail);
            token_t t;
            if (owed_q.size() == 0) begin
                report_mismatch($sformatf("token kind %0d value %0d with none expected",
                                          kind, value));
                return;
            end
            t = owed_q.pop_front();
            checked++;
            if (kind !== t.kind)
                report_mismatch($sformatf("token %0d: kind %0d, expected %0d",
                                          checked, kind, t.kind));
            if (value !== t.value)
                report_mismatch($sformatf("token %0d: value %0d, expected %0d",
                                          checked, value, t.value));
            if (tail !== t.tail)
                report_mismatch($sformatf("token %0d: m_tlast %0b, expected %0b",
                                          checked, tail, t.tail));
        endtask
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;

    token_scoreboard sb;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  chars_sent     = 0;
    int  exprs_sent     = 0;
    int  cycle_count    = 0;

    string      pair_ops[6]   = '{"==", "!=", "<=", ">=", "&&", "||"};
    string      single_ops[12] = '{"+", "-", "*", "/", "%", "?", ":", "(", ")",
                                   "<", ">", "!"};
    string      lone_ops[3]   = '{"=", "&", "|"};
    logic [7:0] blanks[6]     = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    plural_expression_tokenizer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Receiver back-pressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Token monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_token(m_tdata[4:0], m_tdata[5 +: plex_pkg::OUT_VALUE_W], m_tlast);
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("plural_expression_tokenizer: mismatch");
            $finish;
        end
    end

    // Random sender gaps; valid drops only for whole cycles
    task automatic idle_gap();
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_beat(input logic [7:0] c, input bit present, input bit last);
        idle_gap();
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= present;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_char(c, present, last);
        if (present)
            chars_sent++;
        if (last)
            exprs_sent++;
    endtask

    // Whole expression; last flag on the final character
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b1, i == s.len() - 1);
    endtask

    function automatic void append_text(ref char_beat_t q[$], input string s);
        char_beat_t b;
        for (int i = 0; i < s.len(); i++) begin
            b.code    = s[i];
            b.present = 1'b1;
            q.push_back(b);
        end
    endfunction

    // Random expression: mostly token pieces, some noise bytes and bubbles
    task automatic send_expression();
        char_beat_t seq[$];
        char_beat_t b;
        int         pieces;
        int         ndig;
        pieces = ($urandom_range(99) < 3) ? 0 : $urandom_range(1, 9);
        for (int p = 0; p < pieces; p++) begin
            case ($urandom_range(19))
                0, 1, 2:  append_text(seq, "n");
                3, 4, 5, 6: begin
                    // long runs can wrap the 64-bit value
                    ndig = ($urandom_range(5) == 0) ? $urandom_range(18, 26)
                                                    : $urandom_range(1, 3);
                    for (int d = 0; d < ndig; d++) begin
                        b.code    = 8'("0" + $urandom_range(9));
                        b.present = 1'b1;
                        seq.push_back(b);
                    end
                end
                7:        append_text(seq, "18446744073709551615");
                8, 9, 10: append_text(seq, pair_ops[$urandom_range(5)]);
                11, 12, 13: append_text(seq, single_ops[$urandom_range(11)]);
                14: begin
                    b.code    = blanks[$urandom_range(5)];
                    b.present = 1'b1;
                    seq.push_back(b);
                end
                15:       append_text(seq, lone_ops[$urandom_range(2)]);
                16, 17: begin
                    b.code    = 8'($urandom_range(255));
                    b.present = 1'b1;
                    seq.push_back(b);
                end
                default: begin
                    // bubble: no character, random code bits
                    b.code    = 8'($urandom_range(255));
                    b.present = 1'b0;
                    seq.push_back(b);
                end
            endcase
        end
        // empty expression or a trailing bubble carries the last flag
        if (seq.size() == 0 || $urandom_range(99) < 8) begin
            b.code    = 8'($urandom_range(255));
            b.present = 1'b0;
            seq.push_back(b);
        end
        foreach (seq[i])
            send_beat(seq[i].code, seq[i].present, i == seq.size() - 1);
    endtask

    task automatic run_phase(input int nchars);
        int target;
        target = chars_sent + nchars;
        while (chars_sent < target)
            send_expression();
    endtask

    // Stimulus
    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty expression, bubbles inside a number, last as bubble
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat("1", 1'b1, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        // byte extremes skipped, pairs vs. singles, three tokens from one byte
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'h80, 1'b1, 1'b0);
        send_text(">=<9\t!(");
        // lone = & | dropped, the single operators + - * / % ? : )
        send_text("n=+&-|*/%?:)");
        send_text("==!=&&||");

        // random phases with different pacing
        run_phase(60);
        send_idle_pct = 55;
        run_phase(60);
        // hold off until the block has drained
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.waiting())
            @(posedge clk);
        send_idle_pct  = 0;
        recv_stall_pct = 55;
        run_phase(60);
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        run_phase(60);
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // drain and let the pipeline settle
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.waiting())
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.waiting())
            sb.report_mismatch($sformatf("%0d tokens never arrived", sb.owed_q.size()));

        $display("Sent %0d expressions, %0d characters; %0d tokens checked", exprs_sent,
                 chars_sent, sb.checked);
        $display("Pacing: free-running, sender gaps, receiver stalls, both mixed");
        if (sb.errors == 0)
            $display("plural_expression_tokenizer: match");
        else
            $display("plural_expression_tokenizer: mismatch");
        $finish;
    end

endmodule
